@@ rtl/core/tbad_pkg.sv @@
// Shared widths, register indexes and constants of the traffic burst alarm detector.
package tbad_pkg;

    localparam int BYTE_W   = 32;
    localparam int AVG_W    = 40;
    localparam int FRAC_W   = 8;
    localparam int ALPHA_W  = 16;
    localparam int BURST_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 40;
    localparam int MAX_CONN = 1024;

    // weight of the old average is ONE - alpha, so the multiplier sees one more bit
    localparam int MUL_W    = ALPHA_W + 1;
    localparam int ACC_W    = AVG_W + MUL_W;
    localparam logic [MUL_W-1:0] MUL_ONE = MUL_W'(1) << ALPHA_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ALPHA_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_INIT_AVG  = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_LIMIT     = 2'd3
    } t_cfg_idx;

endpackage

@@ rtl/core/tbad_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module tbad_divider #(
    parameter int DVD_W = 50,
    parameter int DSR_W = 11,
    parameter int QUO_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSR_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_dsr;

    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;
    logic [DSR_W-1:0]  n_rem;
    logic [DVD_W-1:0]  n_quo;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = ~diff[DSR_W];
        // remainder stays below the divisor, so it fits back into DSR_W bits
        n_rem = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        n_quo = {r_quo[DVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QUO_W-1:0];

endmodule

@@ rtl/core/traffic_burst_alarm_detector.sv @@
// Traffic burst alarm detector: a report without an interval close, a relax item and a report
// in alarm each return their result in the cycle after the transfer. A close with active
// connections runs the divider (ST_DIV), then the shift-add EWMA multiplier (ST_MUL), a
// rounding step (ST_RND) and a compare step (ST_CMP), which loads its result into the output
// register; the next item can be taken once the detector is back in idle. The input is not
// ready for the whole close. A new item is taken once the output register is free or being
// drained; a stalled output holds the compare step.
module traffic_burst_alarm_detector #(
    parameter int MAX_CONNECTIONS = tbad_pkg::MAX_CONN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [tbad_pkg::BYTE_W-1:0]       i_byte_count,
    input  logic                              i_last_report,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_alarm,
    output logic                              o_interval_done,
    output logic [tbad_pkg::AVG_W-1:0]        o_interval_average,
    output logic [tbad_pkg::AVG_W-1:0]        o_long_term_average,
    output logic [tbad_pkg::BURST_W-1:0]      o_burst_count,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AVG_W   = tbad_pkg::AVG_W;
    localparam int BURST_W = tbad_pkg::BURST_W;
    localparam int ACC_W   = tbad_pkg::ACC_W;
    localparam int MUL_W   = tbad_pkg::MUL_W;
    localparam int CNT_W   = $clog2(MAX_CONNECTIONS + 1);
    localparam int SUM_W   = tbad_pkg::BYTE_W + $clog2(MAX_CONNECTIONS);
    localparam int DVD_W   = SUM_W + tbad_pkg::FRAC_W;
    localparam int STEP_W  = $clog2(MUL_W);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_RND  = 5'b01000,
        ST_CMP  = 5'b10000
    } t_state;

    t_state                    r_state;

    logic [tbad_pkg::ALPHA_W-1:0] r_alpha;
    logic [AVG_W-1:0]          r_init_avg;
    logic [AVG_W-1:0]          r_threshold;
    logic [BURST_W-1:0]        r_limit;

    logic [SUM_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic [AVG_W-1:0]          r_ewma;
    logic [BURST_W-1:0]        r_bursty;
    logic                      r_alarm;

    logic [AVG_W-1:0]          r_avg;
    logic [AVG_W-1:0]          r_ewma_new;
    logic [ACC_W-1:0]          r_acc;
    logic [STEP_W-1:0]         r_step;

    logic                      r_out_valid;
    logic                      r_out_alarm;
    logic                      r_out_done;
    logic [AVG_W-1:0]          r_out_avg;
    logic [AVG_W-1:0]          r_out_ewma;
    logic [BURST_W-1:0]        r_out_burst;

    logic                      out_free;
    logic                      out_load;
    logic                      in_acc;
    logic                      counted;
    logic [SUM_W-1:0]          n_sum;
    logic [CNT_W-1:0]          n_cnt;
    logic                      close_busy;
    logic                      div_start;
    logic                      div_done;
    logic [AVG_W-1:0]          div_quo;

    logic [MUL_W-1:0]          wt_new;
    logic [MUL_W-1:0]          wt_old;
    logic [ACC_W-1:0]          n_acc;
    logic [ACC_W-1:0]          rnd_sum;
    logic [AVG_W:0]            dev;
    logic                      bursty;

    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) & out_free;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid & o_in_ready;

    // accumulate the report before any close decision
    always_comb begin
        counted = (i_byte_count != '0) & (r_cnt < CNT_W'(MAX_CONNECTIONS));
        n_sum   = counted ? r_sum + SUM_W'(i_byte_count) : r_sum;
        n_cnt   = counted ? r_cnt + CNT_W'(1) : r_cnt;
    end

    assign close_busy = in_acc & ~i_op & ~r_alarm & i_last_report & (n_cnt != '0);
    assign div_start  = close_busy;

    // load the output register with a result that needs no close sequence or with a finished close
    assign out_load   = (in_acc & ~close_busy) | ((r_state == ST_CMP) & out_free);

    tbad_divider #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W),
        .QUO_W (AVG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_sum, {tbad_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (n_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // MSB-first shift-add over both weights at once
    always_comb begin
        wt_new  = {1'b0, r_alpha};
        wt_old  = tbad_pkg::MUL_ONE - {1'b0, r_alpha};
        n_acc   = {r_acc[ACC_W-2:0], 1'b0}
                + (wt_new[r_step] ? ACC_W'(r_avg) : '0)
                + (wt_old[r_step] ? ACC_W'(r_ewma) : '0);
        rnd_sum = r_acc + tbad_pkg::ROUND_HALF;
        dev     = {1'b0, r_avg} - {1'b0, r_ewma_new};
        // positive deviation beyond the threshold; zero deviation never exceeds it
        bursty  = ~dev[AVG_W] & (dev[AVG_W-1:0] > r_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= '0;
            r_init_avg  <= '0;
            r_threshold <= '0;
            r_limit     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tbad_pkg::t_cfg_idx'(i_cfg_index))
                tbad_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data[tbad_pkg::ALPHA_W-1:0];
                tbad_pkg::CFG_INIT_AVG:  r_init_avg  <= i_cfg_data[AVG_W-1:0];
                tbad_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[AVG_W-1:0];
                tbad_pkg::CFG_LIMIT:     r_limit     <= i_cfg_data[BURST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ewma      <= '0;
            r_bursty    <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_op) begin
                            if (r_alarm) begin
                                r_alarm  <= 1'b0;
                                r_bursty <= '0;
                                r_sum    <= '0;
                                r_cnt    <= '0;
                                r_ewma   <= r_init_avg;
                            end
                            r_out_alarm <= 1'b0;
                            r_out_done  <= 1'b0;
                            r_out_avg   <= '0;
                            r_out_ewma  <= r_alarm ? r_init_avg : r_ewma;
                            r_out_burst <= r_alarm ? '0 : r_bursty;
                        end else begin
                            if (!r_alarm) begin
                                if (i_last_report) begin
                                    r_sum <= '0;
                                    r_cnt <= '0;
                                end else begin
                                    r_sum <= n_sum;
                                    r_cnt <= n_cnt;
                                end
                            end
                            if (close_busy) begin
                                r_state <= ST_DIV;
                            end else begin
                                r_out_alarm <= r_alarm;
                                r_out_done  <= 1'b0;
                                r_out_avg   <= '0;
                                r_out_ewma  <= r_ewma;
                                r_out_burst <= r_bursty;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_MUL;
                        r_step  <= STEP_W'(MUL_W - 1);
                    end
                end
                ST_MUL: begin
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                        r_ewma      <= r_ewma_new;
                        r_out_done  <= 1'b1;
                        r_out_avg   <= r_avg;
                        r_out_ewma  <= r_ewma_new;
                        if (!bursty) begin
                            r_bursty    <= '0;
                            r_out_burst <= '0;
                            r_out_alarm <= r_alarm;
                        end else if (r_bursty < r_limit) begin
                            r_bursty    <= r_bursty + BURST_W'(1);
                            r_out_burst <= r_bursty + BURST_W'(1);
                            r_out_alarm <= r_alarm;
                        end else begin
                            r_alarm     <= 1'b1;
                            r_out_burst <= r_bursty;
                            r_out_alarm <= 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers of the close sequence
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_avg <= div_quo;
            r_acc <= '0;
        end else if (r_state == ST_MUL) begin
            r_acc <= n_acc;
        end
        if (r_state == ST_RND) begin
            r_ewma_new <= rnd_sum[tbad_pkg::ALPHA_W +: AVG_W];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_alarm             = r_out_alarm;
    assign o_interval_done     = r_out_done;
    assign o_interval_average  = r_out_avg;
    assign o_long_term_average = r_out_ewma;
    assign o_burst_count       = r_out_burst;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CONNECTIONS))
        else $error("active connection count beyond its limit");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_sum == '0) && (r_cnt == '0))
        else $error("accumulators not cleared during interval close");

    a_alarm_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_op && r_alarm) |=> $stable(r_sum) && $stable(r_cnt) && r_alarm)
        else $error("report changed state while in alarm");

    a_idle_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_avg == '0))
        else $error("interval average set without a closed interval");

    a_done_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && out_free) |=> r_out_valid && r_out_done)
        else $error("closed interval not reported");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the traffic burst alarm detector: directed and random.
`timescale 1ns / 100ps

module tb;
    import tbad_pkg::*;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_RELAX  = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   SETTLE_CYCLES  = 100;

    typedef struct {
        logic               alarm;
        logic               done;
        logic [AVG_W-1:0]   interval_avg;
        logic [AVG_W-1:0]   long_avg;
        logic [BURST_W-1:0] bursts;
    } t_alarm_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_op = OP_REPORT;
    logic [BYTE_W-1:0]     in_bytes = '0;
    logic                  in_last = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_idx              cfg_index = CFG_ALPHA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_alarm;
    logic                  o_interval_done;
    logic [AVG_W-1:0]      o_interval_average;
    logic [AVG_W-1:0]      o_long_term_average;
    logic [BURST_W-1:0]    o_burst_count;
    logic                  o_cfg_ready;

    // detector state as predicted
    logic [ALPHA_W-1:0]    set_alpha = '0;
    logic [AVG_W-1:0]      set_init_avg = '0;
    logic [AVG_W-1:0]      set_threshold = '0;
    logic [BURST_W-1:0]    set_limit = '0;
    logic [BYTE_W+9:0]     byte_total = '0;
    logic [10:0]           conn_count = '0;
    logic [AVG_W-1:0]      long_avg = '0;
    logic [BURST_W-1:0]    burst_run = '0;
    logic                  alarm_on = 1'b0;

    t_alarm_result pending_results[$];
    int            mismatches = 0;
    int            dead_cycles = 0;
    int            stall_left = 0;
    bit            quiet_mode = 1'b0;

    traffic_burst_alarm_detector i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_op                (in_op),
        .i_byte_count        (in_bytes),
        .i_last_report       (in_last),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_alarm             (o_alarm),
        .o_interval_done     (o_interval_done),
        .o_interval_average  (o_interval_average),
        .o_long_term_average (o_long_term_average),
        .o_burst_count       (o_burst_count),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int idle_length();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic int sender_gap();
        if (quiet_mode || $urandom_range(99) < 65) return 0;
        return idle_length();
    endfunction

    // Fold one accepted item into the predicted state and return its result.
    function automatic t_alarm_result advance_detector(input logic op,
                                                       input logic [BYTE_W-1:0] bytes,
                                                       input logic last);
        t_alarm_result    res;
        logic [63:0]      scaled;
        logic [63:0]      mix;
        logic [AVG_W-1:0] avg;
        logic [AVG_W-1:0] nxt;
        res.done = 1'b0;
        avg = '0;
        if (op == OP_RELAX) begin
            if (alarm_on) begin
                alarm_on = 1'b0;
                burst_run = '0;
                byte_total = '0;
                conn_count = '0;
                long_avg = set_init_avg;
            end
        end else if (!alarm_on) begin
            if (bytes != '0 && conn_count < 11'(MAX_CONN)) begin
                byte_total = byte_total + (BYTE_W+10)'(bytes);
                conn_count = conn_count + 11'd1;
            end
            if (last) begin
                if (conn_count != '0) begin
                    scaled = {14'd0, byte_total, 8'd0};
                    avg = AVG_W'(scaled / 64'(conn_count));
                    mix = 64'(set_alpha) * 64'(avg)
                        + (64'd65536 - 64'(set_alpha)) * 64'(long_avg) + 64'd32768;
                    nxt = mix[ALPHA_W +: AVG_W];
                    long_avg = nxt;
                    res.done = 1'b1;
                    if (avg > nxt && (avg - nxt) > set_threshold) begin
                        if (burst_run < set_limit) burst_run = burst_run + BURST_W'(1);
                        else alarm_on = 1'b1;
                    end else begin
                        burst_run = '0;
                    end
                end
                byte_total = '0;
                conn_count = '0;
            end
        end
        res.alarm = alarm_on;
        res.interval_avg = avg;
        res.long_avg = long_avg;
        res.bursts = burst_run;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic op, input logic [BYTE_W-1:0] bytes, input logic last);
        int gap;
        gap = sender_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_bytes <= bytes;
        in_last  <= last;
        do @(posedge clk); while (!o_in_ready);
        pending_results.insert(pending_results.size(), advance_detector(op, bytes, last));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Hold valid high across consecutive writes; the caller drops it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_ALPHA:     set_alpha = data[ALPHA_W-1:0];
            CFG_INIT_AVG:  set_init_avg = data[AVG_W-1:0];
            CFG_THRESHOLD: set_threshold = data[AVG_W-1:0];
            CFG_LIMIT:     set_limit = data[BURST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [ALPHA_W-1:0] a, input logic [AVG_W-1:0] init,
                                  input logic [AVG_W-1:0] thr, input logic [BURST_W-1:0] lim);
        wait_drained();
        write_reg(CFG_ALPHA, CFG_DATA_W'(a));
        write_reg(CFG_INIT_AVG, init);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        apply_settings(16'h8000, 40'd0, 40'd0, 16'd1);
        send_item(OP_RELAX, 32'hFFFF_FFFF, 1'b1);   // relax while normal: no effect
        send_item(OP_REPORT, 32'd0, 1'b1);          // close with nothing counted
        send_item(OP_REPORT, 32'd0, 1'b0);
        send_item(OP_REPORT, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_REPORT, 32'd1, 1'b0);
        send_item(OP_REPORT, 32'h8000_0000, 1'b1);
        send_item(OP_REPORT, 32'd7, 1'b1);          // quiet interval clears the run
        // two spikes: the first counts, the second raises the alarm
        send_item(OP_REPORT, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_REPORT, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_REPORT, 32'h1234_5678, 1'b0);  // dropped during alarm
        send_item(OP_REPORT, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_RELAX, 32'hFFFF_FFFF, 1'b1);   // leave alarm, last flag ignored
        send_item(OP_RELAX, 32'd0, 1'b0);
        send_item(OP_REPORT, 32'h0000_0100, 1'b1);
    endtask

    task automatic run_traffic(input logic [ALPHA_W-1:0] a, input logic [AVG_W-1:0] init,
                               input logic [AVG_W-1:0] thr, input logic [BURST_W-1:0] lim,
                               input bit quiet, input int n_items);
        int          counted;
        int          len;
        int          roll;
        logic [31:0] mask;
        apply_settings(a, init, thr, lim);
        quiet_mode = quiet;
        counted = 0;
        while (counted < n_items) begin
            roll = $urandom_range(99);
            if (alarm_on) begin
                if (roll < 60) begin
                    send_item(OP_RELAX, $urandom, 1'($urandom));
                    counted++;
                end else begin
                    send_item(OP_REPORT, $urandom, 1'($urandom));
                end
            end else if (roll < 6) begin
                send_item(OP_RELAX, $urandom, 1'($urandom));
            end else if (roll < 12) begin
                repeat ($urandom_range(0, 2)) send_item(OP_REPORT, 32'd0, 1'b0);
                send_item(OP_REPORT, 32'd0, 1'b1);
                counted++;
            end else begin
                len = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                roll = $urandom_range(99);
                mask = (roll < 55) ? 32'h0000_03FF :
                       (roll < 80) ? 32'h000F_FFFF : 32'hFFFF_FFFF;
                for (int k = 0; k < len; k++) begin
                    send_item(OP_REPORT, ($urandom_range(9) == 0) ? 32'd0 : ($urandom & mask),
                              k == len - 1);
                    counted++;
                end
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_phases();
        run_traffic(16'h0000, 40'd0, 40'd0, 16'd0, 1'b0, 120);
        run_traffic(16'hFFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 16'hFFFF, 1'b0, 120);
        run_traffic(16'($urandom), {8'($urandom), 32'($urandom)},
                    40'($urandom_range(0, 4095)), 16'($urandom_range(0, 3)), 1'b1, 120);
        run_traffic(16'h0800, {8'd0, 32'($urandom)}, 40'h100, 16'd2, 1'b0, 120);
        run_traffic(16'($urandom), {8'($urandom), 32'($urandom)}, 40'($urandom),
                    16'($urandom_range(0, 5)), 1'b0, 120);
    endtask

    // Result side: random back-pressure, short and long.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_mode && $urandom_range(99) < 30) begin
            out_ready  <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_alarm_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", 64'(o_alarm), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_alarm !== want.alarm)
                    report_mismatch("alarm", 64'(o_alarm), 64'(want.alarm));
                if (o_interval_done !== want.done)
                    report_mismatch("interval_done", 64'(o_interval_done), 64'(want.done));
                if (o_interval_average !== want.interval_avg)
                    report_mismatch("interval_average", 64'(o_interval_average),
                                    64'(want.interval_avg));
                if (o_long_term_average !== want.long_avg)
                    report_mismatch("long_term_average", 64'(o_long_term_average),
                                    64'(want.long_avg));
                if (o_burst_count !== want.bursts)
                    report_mismatch("burst_count", 64'(o_burst_count), 64'(want.bursts));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            dead_cycles <= 0;
        end else if (dead_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_phases();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ traffic_burst_alarm_detector.f @@
rtl/core/tbad_pkg.sv
rtl/core/tbad_divider.sv
rtl/core/traffic_burst_alarm_detector.sv
test/tb.sv
